/* rtl/union_find_equality_checker_defines.svh */
// Assertion macros shared by the union-find equality checker RTL.
`ifndef UNION_FIND_EQUALITY_CHECKER_DEFINES_SVH
`define UNION_FIND_EQUALITY_CHECKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define UFEC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ufec: check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define UFEC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ufec: check failed");

`endif

/* rtl/ufec_pkg.sv */
// Package: controller states, find return codes and rank constants.
`timescale 1ns / 1ps
`default_nettype none
package ufec_pkg;

	localparam int RANK_W = 4;
	localparam logic [RANK_W-1:0] RANK_TOP = 4'd15;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_LOOK_RD,
		ST_LOOK_CMP,
		ST_ACT,
		ST_FIND_RD,
		ST_FIND_EV,
		ST_CMP_RD,
		ST_CMP_EV,
		ST_MRG_A,
		ST_MRG_B,
		ST_MRG_WR,
		ST_POST,
		ST_CHK_RD,
		ST_CHK_LD,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		RET_A,
		RET_B,
		RET_PA,
		RET_PB
	} fret_t;

endpackage
`default_nettype wire

/* rtl/union_find_equality_checker.sv */
// Top level: union-find equality checker controller with its state memories.
//
// Usage: drive left_value, right_value, is_equal and last_of_case with start
// high; the transaction is taken at a clock edge where start is high and busy
// is low. Each side's label is looked up by scanning the label memory over
// the stored nodes, and a new label gets the next node id. An equality
// runs two finds through the parent memory (a walk to the root, then a
// second walk for path compression) and, for distinct roots, a rank read
// and merge. An inequality writes one pair if the pair memory has room.
// The parent memory port sets the find cost, the label memory port the lookup
// cost. On a transaction with last_of_case set, each stored pair is read and
// both ends are found, stopping at the first pair whose ends share a root;
// then done pulses for one cycle with consistent and overflow, and the case
// counters clear. Other transactions give no result.
// The receiver cannot stall: the result is valid only in the done cycle.
// Reset clears the controller and counters; memories need no clearing since
// only entries below the counters are ever read.
`timescale 1ns / 1ps
`default_nettype none
`include "union_find_equality_checker_defines.svh"
module union_find_equality_checker #(
	parameter int MAX_NODES = 2048,
	parameter int MAX_PAIRS = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] left_value,
	input  wire logic signed [31:0] right_value,
	input  wire logic               is_equal,
	input  wire logic               last_of_case,
	output logic                    done,
	output logic                    consistent,
	output logic                    overflow
);
	import ufec_pkg::*;

	localparam int ID_W = $clog2(MAX_NODES);
	localparam int NC_W = $clog2(MAX_NODES + 1);
	localparam int PA_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
	localparam int PC_W = $clog2(MAX_PAIRS + 1);

	state_t state_q, state_d;
	fret_t  ret_q;

	logic [31:0]      lval_q, rval_q;
	logic             eq_q, last_q, side_q;
	logic [NC_W-1:0]  scan_q, node_cnt_q;
	logic [PC_W-1:0]  pair_cnt_q, chk_q;
	logic             ovf_q, ok_q, have_a_q, have_b_q;
	logic [ID_W-1:0]  ida_q, idb_q, cur_q, walk_q, top_q, ra_q, rb_q, pb_q;
	logic [RANK_W-1:0] rka_q;

	// memory ports
	logic              l_we, p_we, r_we, q_we;
	logic [ID_W-1:0]   l_addr, p_addr, r_addr, p_wd;
	logic [PA_W-1:0]   q_addr;
	logic [31:0]       l_wd, l_rd;
	logic [ID_W-1:0]   p_rd;
	logic [RANK_W-1:0] r_wd, r_rd;
	logic [2*ID_W-1:0] q_wd, q_rd;

	ufec_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_label (
		.clk(clk), .we(l_we), .addr(l_addr), .wdata(l_wd), .rdata(l_rd)
	);
	ufec_ram #(.WIDTH(ID_W), .DEPTH(MAX_NODES)) u_parent (
		.clk(clk), .we(p_we), .addr(p_addr), .wdata(p_wd), .rdata(p_rd)
	);
	ufec_ram #(.WIDTH(RANK_W), .DEPTH(MAX_NODES)) u_rank (
		.clk(clk), .we(r_we), .addr(r_addr), .wdata(r_wd), .rdata(r_rd)
	);
	ufec_ram #(.WIDTH(2*ID_W), .DEPTH(MAX_PAIRS)) u_pair (
		.clk(clk), .we(q_we), .addr(q_addr), .wdata(q_wd), .rdata(q_rd)
	);

	// label of the side under lookup and lookup outcomes
	logic [31:0] side_val;
	logic        scan_end, node_full, label_hit, find_done, pair_room;
	logic        rk_swap, rk_bump;
	logic [ID_W-1:0] mrg_root, mrg_child;

	assign side_val  = side_q ? rval_q : lval_q;
	assign scan_end  = (scan_q == node_cnt_q);
	assign node_full = (node_cnt_q == NC_W'(MAX_NODES));
	assign label_hit = (l_rd == side_val);
	assign find_done = (p_rd == walk_q);
	assign pair_room = (pair_cnt_q < PC_W'(MAX_PAIRS));
	assign rk_swap   = (rka_q < r_rd);
	assign rk_bump   = (rka_q == r_rd) && (rka_q < RANK_TOP);
	assign mrg_root  = rk_swap ? rb_q : ra_q;
	assign mrg_child = rk_swap ? ra_q : rb_q;

	assign busy       = (state_q != ST_IDLE);
	assign done       = (state_q == ST_EMIT);
	assign consistent = ok_q;
	assign overflow   = ovf_q;

	// hold controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory controls
	always_comb begin
		state_d = state_q;
		l_we = 1'b0; l_addr = scan_q[ID_W-1:0]; l_wd = side_val;
		p_we = 1'b0; p_addr = cur_q; p_wd = node_cnt_q[ID_W-1:0];
		r_we = 1'b0; r_addr = ra_q; r_wd = '0;
		q_we = 1'b0; q_addr = chk_q[PA_W-1:0]; q_wd = {ida_q, idb_q};
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_LOOK_RD;
			end
			ST_LOOK_RD: begin
				if (scan_end) begin
					if (!node_full) begin
						l_we = 1'b1; l_addr = node_cnt_q[ID_W-1:0];
						p_we = 1'b1; p_addr = node_cnt_q[ID_W-1:0];
						r_we = 1'b1; r_addr = node_cnt_q[ID_W-1:0];
					end
					state_d = side_q ? ST_ACT : ST_LOOK_RD;
				end else begin
					state_d = ST_LOOK_CMP;
				end
			end
			ST_LOOK_CMP: begin
				if (label_hit && side_q) state_d = ST_ACT;
				else state_d = ST_LOOK_RD;
			end
			ST_ACT: begin
				if (have_a_q && have_b_q && eq_q) begin
					state_d = ST_FIND_RD;
				end else begin
					if (have_a_q && have_b_q && pair_room) begin
						q_we = 1'b1; q_addr = pair_cnt_q[PA_W-1:0];
					end
					state_d = ST_POST;
				end
			end
			ST_FIND_RD: state_d = ST_FIND_EV;
			ST_FIND_EV: begin
				state_d = (p_rd == cur_q) ? ST_CMP_RD : ST_FIND_RD;
			end
			ST_CMP_RD: begin
				p_addr = walk_q;
				state_d = ST_CMP_EV;
			end
			ST_CMP_EV: begin
				if (find_done) begin
					case (ret_q)
						RET_A:   state_d = ST_FIND_RD;
						RET_B:   state_d = ST_MRG_A;
						RET_PA:  state_d = ST_FIND_RD;
						RET_PB:  state_d = (ra_q == top_q) ? ST_EMIT : ST_CHK_RD;
						default: state_d = ST_IDLE;
					endcase
				end else begin
					p_we = 1'b1; p_addr = walk_q; p_wd = top_q;
					state_d = ST_CMP_RD;
				end
			end
			ST_MRG_A: begin
				r_addr = ra_q;
				state_d = (ra_q == rb_q) ? ST_POST : ST_MRG_B;
			end
			ST_MRG_B: begin
				r_addr = rb_q;
				state_d = ST_MRG_WR;
			end
			ST_MRG_WR: begin
				p_we = 1'b1; p_addr = mrg_child; p_wd = mrg_root;
				r_we = rk_bump; r_addr = mrg_root; r_wd = RANK_W'(rka_q + 4'd1);
				state_d = ST_POST;
			end
			ST_POST: state_d = last_q ? ST_CHK_RD : ST_IDLE;
			ST_CHK_RD: state_d = (chk_q == pair_cnt_q) ? ST_EMIT : ST_CHK_LD;
			ST_CHK_LD: state_d = ST_FIND_RD;
			ST_EMIT:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// update counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_cnt_q <= '0;
			pair_cnt_q <= '0;
			ovf_q      <= 1'b0;
			ok_q       <= 1'b1;
		end else begin
			case (state_q)
				ST_LOOK_RD: begin
					if (scan_end && node_full) ovf_q <= 1'b1;
					else if (scan_end) node_cnt_q <= node_cnt_q + 1'b1;
				end
				ST_ACT: begin
					if (have_a_q && have_b_q && !eq_q) begin
						if (pair_room) pair_cnt_q <= pair_cnt_q + 1'b1;
						else ovf_q <= 1'b1;
					end
				end
				ST_POST: ok_q <= 1'b1;
				ST_CMP_EV: begin
					if (find_done && ret_q == RET_PB && ra_q == top_q) ok_q <= 1'b0;
				end
				ST_EMIT: begin
					node_cnt_q <= '0;
					pair_cnt_q <= '0;
					ovf_q      <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// advance datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				lval_q <= left_value;
				rval_q <= right_value;
				eq_q   <= is_equal;
				last_q <= last_of_case;
				side_q <= 1'b0;
				scan_q <= '0;
			end
			ST_LOOK_RD: begin
				if (scan_end) begin
					if (side_q) begin
						idb_q    <= node_cnt_q[ID_W-1:0];
						have_b_q <= !node_full;
					end else begin
						ida_q    <= node_cnt_q[ID_W-1:0];
						have_a_q <= !node_full;
					end
					side_q <= 1'b1;
					scan_q <= '0;
				end
			end
			ST_LOOK_CMP: begin
				if (label_hit) begin
					if (side_q) begin
						idb_q    <= scan_q[ID_W-1:0];
						have_b_q <= 1'b1;
					end else begin
						ida_q    <= scan_q[ID_W-1:0];
						have_a_q <= 1'b1;
					end
					side_q <= 1'b1;
					scan_q <= '0;
				end else begin
					scan_q <= scan_q + 1'b1;
				end
			end
			ST_ACT: begin
				cur_q  <= ida_q;
				walk_q <= ida_q;
				ret_q  <= RET_A;
			end
			ST_FIND_EV: begin
				if (p_rd == cur_q) top_q <= cur_q;
				else cur_q <= p_rd;
			end
			ST_CMP_EV: begin
				if (find_done) begin
					case (ret_q)
						RET_A: begin
							ra_q   <= top_q;
							cur_q  <= idb_q;
							walk_q <= idb_q;
							ret_q  <= RET_B;
						end
						RET_B: rb_q <= top_q;
						RET_PA: begin
							ra_q   <= top_q;
							cur_q  <= pb_q;
							walk_q <= pb_q;
							ret_q  <= RET_PB;
						end
						RET_PB: chk_q <= chk_q + 1'b1;
						default: ;
					endcase
				end else begin
					walk_q <= p_rd;
				end
			end
			ST_MRG_B: rka_q <= r_rd;
			ST_POST: chk_q <= '0;
			ST_CHK_LD: begin
				cur_q  <= q_rd[2*ID_W-1:ID_W];
				walk_q <= q_rd[2*ID_W-1:ID_W];
				pb_q   <= q_rd[ID_W-1:0];
				ret_q  <= RET_PA;
			end
			default: ;
		endcase
	end

	// checks on counters, the result strobe and start acceptance
	`UFEC_ASSERT_NOW(a_node_cnt_bound, 1'b1, node_cnt_q <= NC_W'(MAX_NODES))
	`UFEC_ASSERT_NOW(a_pair_cnt_bound, 1'b1, pair_cnt_q <= PC_W'(MAX_PAIRS))
	`UFEC_ASSERT_NEXT(a_clear_after_done, done, node_cnt_q == '0 && pair_cnt_q == '0 && !ovf_q)
	`UFEC_ASSERT_NEXT(a_start_takes, start && !busy, busy && !done)
endmodule
`default_nettype wire

/* rtl/ufec_ram.sv */
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module ufec_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  wire logic [WIDTH-1:0]                          wdata,
	output logic      [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write or read one entry per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end else begin
			rdata <= mem_q[addr];
		end
	end
endmodule
`default_nettype wire
